@@ hw/rtl/elfh_pkg.sv @@
// ----------------------------------------------------------------------------
// ELF hash table builder package
// Shared widths, command and status codes, FSM states and the per-byte hash.
// ----------------------------------------------------------------------------
package elfh_pkg;

  // Bucket memory depth and derived index width.
  localparam int BUCKET_DEPTH = 4096;
  localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
  localparam int DIV_W        = SLOT_W + 1;

  // Hash widths and constants of the ELF hash.
  localparam int ACC_W      = 32;
  localparam int HASH_W     = 28;
  localparam int BYTE_SHIFT = 4;
  localparam int FOLD_SHIFT = 24;
  localparam logic [ACC_W-1:0] FOLD_MASK = 32'h0000_00f0;

  // Symbol counter and table limit (the lower of the table size and counter range).
  localparam int SYM_W = 16;
  localparam logic [SYM_W-1:0] SYM_LIMIT = 16'hffff;

  // Remainder unit: bits of the dividend retired per cycle.
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = HASH_W / DIV_DIGIT;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int CFG_W = 13;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_e;

  typedef enum logic {
    KIND_CHAIN = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LINK,
    ST_RDOUT
  } state_e;

  // One byte of the ELF hash: shift in the byte, then fold the top nibble down.
  function automatic logic [ACC_W-1:0] hash_step(input logic [ACC_W-1:0] acc,
                                                  input logic [7:0] name_byte);
    logic [ACC_W-1:0] h;
    h = (acc << BYTE_SHIFT) + {{(ACC_W-8){1'b0}}, name_byte};
    h = h ^ ((h >> FOLD_SHIFT) & FOLD_MASK);
    return h;
  endfunction

endpackage

@@ hw/rtl/elfh_mod.sv @@
// ----------------------------------------------------------------------------
// ELF hash remainder unit
// Restoring remainder of the 28-bit hash by the bucket count, four bits per cycle.
// ----------------------------------------------------------------------------
module elfh_mod (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [elfh_pkg::HASH_W-1:0]     dividend_i,
  input  logic [elfh_pkg::DIV_W-1:0]      divisor_i,
  output logic                            done_o,
  output logic [elfh_pkg::SLOT_W-1:0]     rem_o
);

  logic                            run_q, run_d;
  logic                            done_q, done_d;
  logic [elfh_pkg::STEP_W-1:0]     step_q, step_d;
  logic [elfh_pkg::HASH_W-1:0]     num_q, num_d;
  logic [elfh_pkg::DIV_W-1:0]      den_q, den_d;
  logic [elfh_pkg::SLOT_W-1:0]     rem_q, rem_d;
  logic [elfh_pkg::SLOT_W-1:0]     rem_next;

  // The running remainder stays below the divisor, so each partial value
  // is below twice the divisor and one compare and subtract suffices.
  always_comb begin
    logic [elfh_pkg::DIV_W-1:0]  part;
    logic [elfh_pkg::SLOT_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < elfh_pkg::DIV_DIGIT; i++) begin
      part = {r, num_q[elfh_pkg::HASH_W-1-i]};
      if (part >= den_q) begin
        part = part - den_q;
      end
      r = part[elfh_pkg::SLOT_W-1:0];
    end
    rem_next = r;
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (run_q) begin
      num_d  = num_q << elfh_pkg::DIV_DIGIT;
      rem_d  = rem_next;
      step_d = elfh_pkg::STEP_W'(step_q + 1'b1);
      if (step_q == elfh_pkg::STEP_W'(elfh_pkg::DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < den_q))
    else $error("remainder not below divisor");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("remainder reported while still running");

endmodule

@@ hw/rtl/elf_sysv_hash_table_builder.sv @@
// ----------------------------------------------------------------------------
// ELF System V hash table builder
// Hashes symbol names byte by byte, files each name into its bucket while the
// table has room, reports the chain entry; clears the table, reads bucket heads.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  --------  -----------------------  ------------------------------------------
//  command   start & !busy            cmd_i, name_byte_i, name_end_i, read_slot_i
//  result    result_strobe_o (1 cyc)  result_kind_o, sym_num_o, name_hash_o,
//                                     bucket_slot_o, chain_link_o, bucket_value_o,
//                                     status_o
//  config    cfg_we_i                 cfg_wdata_i (bucket count)
//
// A name byte without end mark leaves busy low. A name's last byte keeps busy
// high while the remainder unit works (28 hash bits, 4 per cycle), then for the
// bucket memory read and the write-back; when the table is full the name is
// dropped after the remainder. A read beat keeps busy high for the memory read.
// A clear beat, and reset, start a clearing pass over all 4096 buckets that
// zeroes one bucket per cycle. The result of a beat is on the output registers
// for one cycle; the receiver cannot stall, and the next beat may be accepted
// while a result is shown.
//
module elf_sysv_hash_table_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [elfh_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd_i,
  input  logic [7:0]                          name_byte_i,
  input  logic                                name_end_i,
  input  logic [elfh_pkg::SLOT_W-1:0]         read_slot_i,
  output logic                                result_strobe_o,
  output logic                                result_kind_o,
  output logic [elfh_pkg::SYM_W-1:0]          sym_num_o,
  output logic [elfh_pkg::HASH_W-1:0]         name_hash_o,
  output logic [elfh_pkg::SLOT_W-1:0]         bucket_slot_o,
  output logic [elfh_pkg::SYM_W-1:0]          chain_link_o,
  output logic [elfh_pkg::SYM_W-1:0]          bucket_value_o,
  output logic [1:0]                          status_o
);

  // Control state.
  elfh_pkg::state_e                   state_q, state_d;
  logic [elfh_pkg::SLOT_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic [elfh_pkg::ACC_W-1:0]         acc_q, acc_d;
  logic [elfh_pkg::SYM_W-1:0]         sym_cnt_q, sym_cnt_d;
  logic [elfh_pkg::CFG_W-1:0]         bucket_count_q;

  // Per-beat payload held across the multi-cycle operations.
  logic [elfh_pkg::SLOT_W-1:0]        slot_q, slot_d;
  logic [elfh_pkg::HASH_W-1:0]        hash_q, hash_d;
  logic                               oor_q, oor_d;

  // Result registers.
  logic                               out_vld_q, out_vld_d;
  elfh_pkg::kind_e                    out_kind_q, out_kind_d;
  logic [elfh_pkg::SYM_W-1:0]         out_index_q, out_index_d;
  logic [elfh_pkg::HASH_W-1:0]        out_hash_q, out_hash_d;
  logic [elfh_pkg::SLOT_W-1:0]        out_slot_q, out_slot_d;
  logic [elfh_pkg::SYM_W-1:0]         out_link_q, out_link_d;
  logic [elfh_pkg::SYM_W-1:0]         out_value_q, out_value_d;
  elfh_pkg::stat_e                    out_status_q, out_status_d;

  // Bucket memory and its ports.
  logic [elfh_pkg::SYM_W-1:0]         heads_mem [elfh_pkg::BUCKET_DEPTH];
  logic [elfh_pkg::SYM_W-1:0]         rdata_q;
  logic                               mem_we, mem_re;
  logic [elfh_pkg::SLOT_W-1:0]        mem_waddr, mem_raddr;
  logic [elfh_pkg::SYM_W-1:0]         mem_wdata;

  // Remainder unit.
  logic                               div_start;
  logic [elfh_pkg::HASH_W-1:0]        div_dividend;
  logic                               div_done;
  logic [elfh_pkg::SLOT_W-1:0]        div_rem;

  logic [elfh_pkg::ACC_W-1:0]         acc_next;
  logic [elfh_pkg::DIV_W-1:0]         n_use;
  logic [elfh_pkg::SYM_W-1:0]         sym_inc;
  logic                               table_full;
  logic                               accept;

  // Bucket count in use: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (bucket_count_q == '0) begin
      n_use = elfh_pkg::DIV_W'(1);
    end else if (bucket_count_q > elfh_pkg::CFG_W'(elfh_pkg::BUCKET_DEPTH)) begin
      n_use = elfh_pkg::DIV_W'(elfh_pkg::BUCKET_DEPTH);
    end else begin
      n_use = elfh_pkg::DIV_W'(bucket_count_q);
    end
  end

  assign accept     = start && (state_q == elfh_pkg::ST_IDLE);
  assign busy       = (state_q != elfh_pkg::ST_IDLE);
  assign acc_next   = elfh_pkg::hash_step(acc_q, name_byte_i);
  assign sym_inc    = elfh_pkg::SYM_W'(sym_cnt_q + 1'b1);
  assign table_full = (sym_cnt_q >= elfh_pkg::SYM_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= elfh_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  // Next state and datapath control. Accesses to the bucket memory never
  // overlap: the read-modify-write of a name finishes before busy drops, so
  // the next read always sees the written head and no forwarding is needed.
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    acc_d        = acc_q;
    sym_cnt_d    = sym_cnt_q;
    slot_d       = slot_q;
    hash_d       = hash_q;
    oor_d        = oor_q;
    out_vld_d    = 1'b0;
    out_kind_d   = out_kind_q;
    out_index_d  = out_index_q;
    out_hash_d   = out_hash_q;
    out_slot_d   = out_slot_q;
    out_link_d   = out_link_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_q;
    mem_wdata    = sym_inc;
    mem_re       = 1'b0;
    mem_raddr    = read_slot_i;
    div_start    = 1'b0;
    div_dividend = acc_next[elfh_pkg::HASH_W-1:0];

    unique case (state_q)
      elfh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = elfh_pkg::SLOT_W'(clr_cnt_q + 1'b1);
        if (clr_cnt_q == '1) begin
          state_d = elfh_pkg::ST_IDLE;
        end
      end
      elfh_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            elfh_pkg::CMD_CLEAR: begin
              acc_d     = '0;
              sym_cnt_d = '0;
              clr_cnt_d = '0;
              state_d   = elfh_pkg::ST_CLEAR;
            end
            elfh_pkg::CMD_BYTE: begin
              acc_d = acc_next;
              if (name_end_i) begin
                acc_d     = '0;
                hash_d    = acc_next[elfh_pkg::HASH_W-1:0];
                div_start = 1'b1;
                state_d   = elfh_pkg::ST_DIV;
              end
            end
            elfh_pkg::CMD_READ: begin
              mem_re  = 1'b1;
              slot_d  = read_slot_i;
              oor_d   = ({1'b0, read_slot_i} >= n_use);
              state_d = elfh_pkg::ST_RDOUT;
            end
            default: begin
            end
          endcase
        end
      end
      elfh_pkg::ST_DIV: begin
        if (div_done) begin
          slot_d = div_rem;
          if (table_full) begin
            out_vld_d    = 1'b1;
            out_kind_d   = elfh_pkg::KIND_CHAIN;
            out_index_d  = '0;
            out_hash_d   = hash_q;
            out_slot_d   = div_rem;
            out_link_d   = '0;
            out_value_d  = '0;
            out_status_d = elfh_pkg::STAT_FULL;
            state_d      = elfh_pkg::ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = div_rem;
            state_d   = elfh_pkg::ST_LINK;
          end
        end
      end
      elfh_pkg::ST_LINK: begin
        // The old head becomes the chain entry, the new symbol the head.
        mem_we       = 1'b1;
        sym_cnt_d    = sym_inc;
        out_vld_d    = 1'b1;
        out_kind_d   = elfh_pkg::KIND_CHAIN;
        out_index_d  = sym_inc;
        out_hash_d   = hash_q;
        out_slot_d   = slot_q;
        out_link_d   = rdata_q;
        out_value_d  = '0;
        out_status_d = elfh_pkg::STAT_OK;
        state_d      = elfh_pkg::ST_IDLE;
      end
      elfh_pkg::ST_RDOUT: begin
        out_vld_d    = 1'b1;
        out_kind_d   = elfh_pkg::KIND_READ;
        out_index_d  = '0;
        out_hash_d   = '0;
        out_slot_d   = slot_q;
        out_link_d   = '0;
        out_value_d  = oor_q ? '0 : rdata_q;
        out_status_d = oor_q ? elfh_pkg::STAT_RANGE : elfh_pkg::STAT_OK;
        state_d      = elfh_pkg::ST_IDLE;
      end
      default: begin
        state_d = elfh_pkg::ST_IDLE;
      end
    endcase
  end

  // Reset starts with a clearing pass over the whole bucket memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= elfh_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      acc_q     <= '0;
      sym_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      acc_q     <= acc_d;
      sym_cnt_q <= sym_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    hash_q       <= hash_d;
    oor_q        <= oor_d;
    out_kind_q   <= out_kind_d;
    out_index_q  <= out_index_d;
    out_hash_q   <= out_hash_d;
    out_slot_q   <= out_slot_d;
    out_link_q   <= out_link_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // Bucket heads: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heads_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= heads_mem[mem_raddr];
    end
  end

  elfh_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_use),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign result_strobe_o = out_vld_q;
  assign result_kind_o   = out_kind_q;
  assign sym_num_o       = out_index_q;
  assign name_hash_o     = out_hash_q;
  assign bucket_slot_o   = out_slot_q;
  assign chain_link_o    = out_link_q;
  assign bucket_value_o  = out_value_q;
  assign status_o        = out_status_q;

  // A result only ever follows a name lookup, a finished remainder or a read.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($past(state_q) == elfh_pkg::ST_LINK ||
                   $past(state_q) == elfh_pkg::ST_RDOUT ||
                   $past(state_q) == elfh_pkg::ST_DIV))
    else $error("result beat without a source operation");

  // No two result beats are back to back: every reporting state returns to idle, which reports nothing.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |=> !out_vld_q)
    else $error("result beats in consecutive cycles");

  // A new symbol number is always reported as an ok chain entry.
  a_counter_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sym_cnt_q != $past(sym_cnt_q) && sym_cnt_q != '0) |->
      (out_vld_q && out_index_q == sym_cnt_q && out_status_q == elfh_pkg::STAT_OK))
    else $error("symbol counter moved without a chain result");

endmodule

@@ dv/tb_elf_sysv_hash_table_builder.sv @@
// ----------------------------------------------------------------------------
// Testbench for the ELF System V hash table builder
// Drives command beats (clear, name bytes, bucket reads) with bursty pacing,
// walks a short directed list, then random phases across several bucket
// counts. A beat-level predictor of the table supplies the expected result
// beat for every accepted command that produces one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_elf_sysv_hash_table_builder;
  import elfh_pkg::*;

  // The unused command code is ignored by the block and yields no result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The longest quiet stretch of a correct run is a clearing pass (one bucket
  // per cycle) plus a sender gap, so this leaves a wide margin.
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_BEATS = 100;

  // One result beat as the block reports it.
  typedef struct packed {
    kind_e              kind;
    logic [SYM_W-1:0]   sym_index;
    logic [HASH_W-1:0]  hash;
    logic [SLOT_W-1:0]  slot;
    logic [SYM_W-1:0]   link;
    logic [SYM_W-1:0]   head;
    stat_e              status;
  } table_result_t;

  // One row of the directed list. A row is either a bucket count write or a
  // command beat; typed rows carry the result that the beat must produce.
  typedef struct packed {
    logic               is_cfg;
    logic [CFG_W-1:0]   cfg_val;
    logic [1:0]         cmd;
    logic [7:0]         nbyte;
    logic               nend;
    logic [SLOT_W-1:0]  rslot;
    logic               typed;
    table_result_t      want;
  } stim_row_t;

  localparam table_result_t NO_WANT =
    '{KIND_CHAIN, 16'd0, 28'd0, 12'd0, 16'd0, 16'd0, STAT_OK};

  // The directed part starts right after reset, so the bucket count is 1 until
  // the first write. Rows without a typed result are checked by the predictor.
  localparam int DIRECTED_ROWS = 31;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Empty table after reset: bucket 0 reads empty, slot 4095 is out of range.
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd0, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd0, 16'd0, 16'd0, STAT_OK}},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd4095, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd4095, 16'd0, 16'd0, STAT_RANGE}},
    // One-byte names at the byte extremes, both land in the single bucket.
    '{1'b0, 13'd0, CMD_BYTE, 8'h00, 1'b1, 12'd0, 1'b1,
      '{KIND_CHAIN, 16'd1, 28'd0, 12'd0, 16'd0, 16'd0, STAT_OK}},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b1, 12'd0, 1'b1,
      '{KIND_CHAIN, 16'd2, 28'hff, 12'd0, 16'd1, 16'd0, STAT_OK}},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd0, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd0, 16'd0, 16'd2, STAT_OK}},
    // The unused command is dropped even with the end mark set.
    '{1'b0, 13'd0, CMD_UNUSED, 8'ha5, 1'b1, 12'd4095, 1'b0, NO_WANT},
    '{1'b1, 13'd4096, CMD_CLEAR, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd4095, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd4095, 16'd0, 16'd0, STAT_OK}},
    // Eight 0xff bytes push set bits past bit 27, so the fold kicks in.
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'hff, 1'b1, 12'd0, 1'b0, NO_WANT},
    // A clear in the middle of a name drops the partial hash and the count.
    '{1'b0, 13'd0, CMD_BYTE, 8'h41, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_CLEAR, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'h42, 1'b1, 12'd0, 1'b1,
      '{KIND_CHAIN, 16'd1, 28'h42, 12'd66, 16'd0, 16'd0, STAT_OK}},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd66, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd66, 16'd0, 16'd1, STAT_OK}},
    // Zero bytes inside a name are hashed like any other byte.
    '{1'b0, 13'd0, CMD_BYTE, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_BYTE, 8'h01, 1'b1, 12'd0, 1'b1,
      '{KIND_CHAIN, 16'd2, 28'h1, 12'd1, 16'd0, 16'd0, STAT_OK}},
    // A bucket count of zero acts as one bucket.
    '{1'b1, 13'd0, CMD_CLEAR, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd1, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd1, 16'd0, 16'd0, STAT_RANGE}},
    '{1'b0, 13'd0, CMD_BYTE, 8'h07, 1'b1, 12'd0, 1'b1,
      '{KIND_CHAIN, 16'd3, 28'h7, 12'd0, 16'd0, 16'd0, STAT_OK}},
    // A bucket count above the memory depth is clamped to the depth.
    '{1'b1, 13'd8191, CMD_CLEAR, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd4095, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd4095, 16'd0, 16'd0, STAT_OK}},
    '{1'b0, 13'd0, CMD_BYTE, 8'h80, 1'b1, 12'd0, 1'b1,
      '{KIND_CHAIN, 16'd4, 28'h80, 12'd128, 16'd0, 16'd0, STAT_OK}},
    // A read exactly at the bucket count is out of range.
    '{1'b1, 13'd3, CMD_CLEAR, 8'h00, 1'b0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, 13'd0, CMD_READ, 8'h00, 1'b0, 12'd3, 1'b1,
      '{KIND_READ, 16'd0, 28'd0, 12'd3, 16'd0, 16'd0, STAT_RANGE}}
  };

  // Clock and reset. Reset is low from time zero and released once.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Block inputs, all known from the start of the run.
  logic               cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               start       = 1'b0;
  logic [1:0]         cmd_i       = CMD_CLEAR;
  logic [7:0]         name_byte_i = '0;
  logic               name_end_i  = 1'b0;
  logic [SLOT_W-1:0]  read_slot_i = '0;

  // Block outputs.
  logic               busy;
  logic               result_strobe_o;
  logic               result_kind_o;
  logic [SYM_W-1:0]   sym_num_o;
  logic [HASH_W-1:0]  name_hash_o;
  logic [SLOT_W-1:0]  bucket_slot_o;
  logic [SYM_W-1:0]   chain_link_o;
  logic [SYM_W-1:0]   bucket_value_o;
  logic [1:0]         status_o;

  // Side band that travels with each beat: a typed result replaces the
  // predicted one when the beat comes from a typed directed row.
  logic               beat_typed = 1'b0;
  table_result_t      beat_want  = NO_WANT;

  elf_sysv_hash_table_builder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .name_byte_i     (name_byte_i),
    .name_end_i      (name_end_i),
    .read_slot_i     (read_slot_i),
    .result_strobe_o (result_strobe_o),
    .result_kind_o   (result_kind_o),
    .sym_num_o       (sym_num_o),
    .name_hash_o     (name_hash_o),
    .bucket_slot_o   (bucket_slot_o),
    .chain_link_o    (chain_link_o),
    .bucket_value_o  (bucket_value_o),
    .status_o        (status_o)
  );

  // --------------------------------------------------------------------------
  // Table predictor: its own copy of the hash accumulator, the symbol counter,
  // the bucket heads and the bucket count register.
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0]   name_acc_q;
  logic [SYM_W-1:0]   sym_count_q;
  logic [SYM_W-1:0]   bucket_heads_q [BUCKET_DEPTH];
  logic [CFG_W-1:0]   bucket_count_q;

  table_result_t      expected_results [$];
  int unsigned        err_cnt = 0;
  int unsigned        burst_left = 0;

  // Bucket count actually in use: zero means one, above the depth means the depth.
  function automatic int unsigned buckets_used();
    if (bucket_count_q == '0) begin
      return 1;
    end
    if (bucket_count_q > BUCKET_DEPTH) begin
      return BUCKET_DEPTH;
    end
    return bucket_count_q;
  endfunction

  task automatic empty_table();
    name_acc_q  = '0;
    sym_count_q = '0;
    foreach (bucket_heads_q[i]) begin
      bucket_heads_q[i] = '0;
    end
  endtask

  // Advances the table by one accepted command beat and tells whether the
  // beat produces a result, and which.
  task automatic predict_table_beat(input logic [1:0] c, input logic [7:0] b,
                                    input logic e, input logic [SLOT_W-1:0] s,
                                    output bit produced, output table_result_t r);
    int unsigned       n;
    logic [ACC_W-1:0]  h;
    logic [HASH_W-1:0] nh;
    logic [SLOT_W-1:0] sl;
    produced = 1'b0;
    r = NO_WANT;
    n = buckets_used();
    case (c)
      CMD_CLEAR: begin
        empty_table();
      end
      CMD_READ: begin
        produced = 1'b1;
        r.kind = KIND_READ;
        r.slot = s;
        if (s >= n) begin
          r.status = STAT_RANGE;
        end else begin
          r.head = bucket_heads_q[s];
        end
      end
      CMD_BYTE: begin
        // Shift the byte in, then fold the top nibble back into bits 4..7.
        h = (name_acc_q << BYTE_SHIFT) + {{(ACC_W-8){1'b0}}, b};
        h = h ^ ((h >> FOLD_SHIFT) & FOLD_MASK);
        name_acc_q = h;
        if (e) begin
          produced = 1'b1;
          nh = h[HASH_W-1:0];
          sl = SLOT_W'(nh % n);
          name_acc_q = '0;
          r.kind = KIND_CHAIN;
          r.hash = nh;
          r.slot = sl;
          if (sym_count_q >= SYM_LIMIT) begin
            // Table full: the name is dropped and nothing but the hash moves.
            r.status = STAT_FULL;
          end else begin
            r.link = bucket_heads_q[sl];
            sym_count_q = sym_count_q + 1'b1;
            bucket_heads_q[sl] = sym_count_q;
            r.sym_index = sym_count_q;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
    end
  endtask

  // Everything is sampled at the rising edge before the block's registers
  // update, so the beat seen here is the one the block takes at this edge.
  // The result check runs before the new expectation is queued.
  always @(posedge clk_i) begin
    table_result_t want;
    table_result_t predicted;
    bit            produced;
    if (!rst_ni) begin
      bucket_count_q = 13'd1;
      empty_table();
      expected_results.delete();
    end else begin
      if (result_strobe_o) begin
        if (expected_results.size() == 0) begin
          err_cnt++;
          $error("result beat with no expected result waiting");
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("sym_num", want.sym_index, sym_num_o);
          check_field("name_hash", want.hash, name_hash_o);
          check_field("bucket_slot", want.slot, bucket_slot_o);
          check_field("chain_link", want.link, chain_link_o);
          check_field("bucket_value", want.head, bucket_value_o);
          check_field("status", want.status, status_o);
        end
      end
      if (cfg_we_i) begin
        bucket_count_q = cfg_wdata_i;
      end
      if (start && busy === 1'b0) begin
        predict_table_beat(cmd_i, name_byte_i, name_end_i, read_slot_i,
                           produced, predicted);
        if (produced) begin
          expected_results.push_back(beat_typed ? beat_want : predicted);
        end
      end
    end
  end

  // Watchdog: any accepted command or result beat counts as progress.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || result_strobe_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL elf_sysv_hash_table_builder");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side. Every task below starts and ends at a rising edge, and all
  // block inputs change by nonblocking assignment at that edge.
  // --------------------------------------------------------------------------

  // Presents one command beat and holds it until the block takes it.
  task automatic send_beat(input logic [1:0] c, input logic [7:0] b,
                           input logic e, input logic [SLOT_W-1:0] s,
                           input logic typed, input table_result_t want);
    start       <= 1'b1;
    cmd_i       <= c;
    name_byte_i <= b;
    name_end_i  <= e;
    read_slot_i <= s;
    beat_typed  <= typed;
    beat_want   <= want;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
  endtask

  // Bursts of back-to-back beats with idle gaps of random length in between;
  // some bursts run straight into the next with no gap at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Holds the sender off until every expected result has arrived. One edge
  // always passes, so start is never lowered and raised in the same step.
  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // The bucket count is only written with the block idle. A clear beat gives
  // no result, so busy is also waited out to cover a clearing pass.
  task automatic write_bucket_count(input logic [CFG_W-1:0] value);
    wait_results_drained();
    while (busy !== 1'b0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random mix: mostly name bytes that form names of random length, bucket
  // reads (mostly in range), rare clears, unused commands as noise, and now
  // and then a pause until the table has answered everything.
  task automatic run_random_phase(input int beats);
    int unsigned roll;
    int unsigned n;
    logic [SLOT_W-1:0] slot;
    int sent;
    sent = 0;
    while (sent < beats) begin
      roll = $urandom_range(0, 99);
      n = buckets_used();
      if (roll == 0) begin
        send_beat(CMD_CLEAR, 8'($urandom), 1'($urandom), SLOT_W'($urandom),
                  1'b0, NO_WANT);
        sent++;
      end else if (roll < 4) begin
        send_beat(CMD_UNUSED, 8'($urandom), 1'($urandom), SLOT_W'($urandom),
                  1'b0, NO_WANT);
      end else if (roll < 26) begin
        slot = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 4095))
                                           : SLOT_W'($urandom_range(0, n - 1));
        send_beat(CMD_READ, 8'($urandom), 1'($urandom), slot, 1'b0, NO_WANT);
        sent++;
      end else begin
        send_beat(CMD_BYTE, 8'($urandom), ($urandom_range(0, 3) == 0),
                  SLOT_W'($urandom), 1'b0, NO_WANT);
        sent++;
      end
      if ($urandom_range(0, 149) == 0) begin
        wait_results_drained();
      end else begin
        pace_sender();
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_counts [11];
    phase_counts = '{13'd1, 13'd2, 13'd3, 13'd0, 13'd4096, 13'd8191, 13'd17,
                     13'd4097, 13'd5, 13'd1, 13'd1};
    phase_counts[9]  = CFG_W'($urandom_range(1, 4096));
    phase_counts[10] = CFG_W'($urandom_range(0, 8191));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed list.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        write_bucket_count(DIRECTED[i].cfg_val);
      end else begin
        send_beat(DIRECTED[i].cmd, DIRECTED[i].nbyte, DIRECTED[i].nend,
                  DIRECTED[i].rslot, DIRECTED[i].typed, DIRECTED[i].want);
        pace_sender();
      end
    end

    // Random phases, each under its own bucket count, extremes included.
    foreach (phase_counts[p]) begin
      write_bucket_count(phase_counts[p]);
      run_random_phase(RANDOM_BEATS);
    end

    // A clear empties the table, then one more short random phase.
    write_bucket_count(CFG_W'($urandom_range(1, 4096)));
    send_beat(CMD_CLEAR, 8'h00, 1'b0, '0, 1'b0, NO_WANT);
    run_random_phase(20);

    // Let the last results come out, then watch a little longer for strays.
    wait_results_drained();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("PASS elf_sysv_hash_table_builder");
    end else begin
      $display("FAIL elf_sysv_hash_table_builder");
    end
    $finish;
  end

endmodule
